>>> rtl/core/cfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

    // Default receive buffer size in bytes (header, length, command, check + payload)
    localparam int RX_BUFFER_BYTES_DEF = 64;

    // Frame overhead bytes counted against the buffer limit
    localparam int FRAME_OVERHEAD = 5;

    // Width of the length-plus-overhead sum (255 + 5 fits)
    localparam int LEN_SUM_W = 9;

    // Payload bytes kept for decoding
    localparam int STORE_BYTES = 12;
    localparam int STORE_IDX_W = $clog2(STORE_BYTES);

    // Payload lengths each command requires
    localparam logic [7:0] LEN_STOP    = 8'd0;
    localparam logic [7:0] LEN_SET_VEL = 8'd6;
    localparam logic [7:0] LEN_TUNE    = 8'd12;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_STOP           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SET_VELOCITY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_TUNE_GAINS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_STATUS_REQUEST = 3'd5;

    // Configuration reset values
    localparam logic [7:0] HEADER_FIRST_RST        = 8'hAA;
    localparam logic [7:0] HEADER_SECOND_RST       = 8'h55;
    localparam logic [7:0] CODE_STOP_RST           = 8'd1;
    localparam logic [7:0] CODE_SET_VELOCITY_RST   = 8'd2;
    localparam logic [7:0] CODE_TUNE_GAINS_RST     = 8'd3;
    localparam logic [7:0] CODE_STATUS_REQUEST_RST = 8'd4;

    typedef enum logic [2:0] {
        ACT_STOP    = 3'd0,
        ACT_SET_VEL = 3'd1,
        ACT_TUNE    = 3'd2,
        ACT_STATUS  = 3'd3,
        ACT_NONE    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ACK_OK      = 2'd0,
        ACK_BAD_LEN = 2'd1,
        ACK_UNKNOWN = 2'd2
    } ack_t;

    // Live configuration handed to the parser
    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] code_stop;
        logic [7:0] code_set_velocity;
        logic [7:0] code_tune_gains;
        logic [7:0] code_status_request;
    } cfg_t;

    // One decoded result
    typedef struct packed {
        action_t            action;
        ack_t               ack_code;
        logic [7:0]         command_echo;
        logic signed [15:0] vel_forward;
        logic signed [15:0] vel_side;
        logic signed [15:0] turn_rate;
        logic [31:0]        gain_p_bits;
        logic [31:0]        gain_i_bits;
        logic [31:0]        gain_d_bits;
    } result_t;

endpackage : cfr_pkg
`default_nettype wire

>>> rtl/core/cfr_byte_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_byte_if
// Received byte channel: valid/ready with one byte of payload.
// ----------------------------------------------------------------------------
interface cfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface : cfr_byte_if
`default_nettype wire

>>> rtl/core/cfr_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface cfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : cfr_cfg_if
`default_nettype wire

>>> rtl/core/cfr_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_result_if
// Decoded command channel: valid/ready with the decoded fields.
// ----------------------------------------------------------------------------
interface cfr_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [1:0]         ack_code;
    logic [7:0]         command_echo;
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_side;
    logic signed [15:0] turn_rate;
    logic [31:0]        gain_p_bits;
    logic [31:0]        gain_i_bits;
    logic [31:0]        gain_d_bits;

    modport source (
        output valid, output action, output ack_code, output command_echo,
        output vel_forward, output vel_side, output turn_rate,
        output gain_p_bits, output gain_i_bits, output gain_d_bits,
        input  ready
    );
    modport sink (
        input  valid, input action, input ack_code, input command_echo,
        input  vel_forward, input vel_side, input turn_rate,
        input  gain_p_bits, input gain_i_bits, input gain_d_bits,
        output ready
    );
endinterface : cfr_result_if
`default_nettype wire

>>> rtl/core/command_frame_receiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_frame_receiver_top
// Byte-serial command frame parser with XOR check and command decode.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle, sustained while results are taken.
// Path: an accepted check byte passes the input byte register and then the result
//   register before its result is valid.
// A waiting result stalls input only while the held byte is a check byte that passes.
// Reset: configuration returns to its defaults, the parser hunts the first header
//   byte; the payload store is not cleared.
module command_frame_receiver_top
    import cfr_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    cfr_byte_if.sink     rx,
    cfr_cfg_if.sink      cfg,
    cfr_result_if.source result
);

    cfg_t    cfg_live;
    result_t res;
    logic    res_load;
    logic    out_can_load;

    // Configuration registers
    cfr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_live)
    );

    // Frame state machine and decode
    cfr_parser #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx           (rx),
        .cfg          (cfg_live),
        .out_can_load (out_can_load),
        .res_load     (res_load),
        .res          (res)
    );

    // Result register
    cfr_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res_in   (res),
        .can_load (out_can_load),
        .result   (result)
    );

endmodule : command_frame_receiver_top
`default_nettype wire

>>> rtl/core/cfr_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_cfg_regs
// Header bytes and command codes, written through the configuration channel.
// ----------------------------------------------------------------------------
module cfr_cfg_regs
    import cfr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cfr_cfg_if.sink    cfg,
    output cfg_t       cfg_out
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    // Always take writes
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;
    assign cfg_out   = cfg_reg;

    // Decode the register index, drop writes beyond the list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg.index)
                CFG_HEADER_FIRST:        cfg_next.header_first        = cfg.data;
                CFG_HEADER_SECOND:       cfg_next.header_second       = cfg.data;
                CFG_CODE_STOP:           cfg_next.code_stop           = cfg.data;
                CFG_CODE_SET_VELOCITY:   cfg_next.code_set_velocity   = cfg.data;
                CFG_CODE_TUNE_GAINS:     cfg_next.code_tune_gains     = cfg.data;
                CFG_CODE_STATUS_REQUEST: cfg_next.code_status_request = cfg.data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first        <= HEADER_FIRST_RST;
            cfg_reg.header_second       <= HEADER_SECOND_RST;
            cfg_reg.code_stop           <= CODE_STOP_RST;
            cfg_reg.code_set_velocity   <= CODE_SET_VELOCITY_RST;
            cfg_reg.code_tune_gains     <= CODE_TUNE_GAINS_RST;
            cfg_reg.code_status_request <= CODE_STATUS_REQUEST_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule : cfr_cfg_regs
`default_nettype wire

>>> rtl/core/cfr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_parser
// Input byte register, per-byte frame state machine, payload store and decode.
// ----------------------------------------------------------------------------
module cfr_parser
    import cfr_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cfr_byte_if.sink   rx,
    input  cfg_t       cfg,
    input  wire logic  out_can_load,
    output logic       res_load,
    output result_t    res
);

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LEN     = 3'd2,
        PH_CMD     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    localparam logic [LEN_SUM_W-1:0] LenLimit    = LEN_SUM_W'(RX_BUFFER_BYTES);
    localparam logic [LEN_SUM_W-1:0] OverheadLen = LEN_SUM_W'(FRAME_OVERHEAD);
    localparam logic [7:0]           StoreBytes8 = 8'(STORE_BYTES);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] frame_command_reg, frame_command_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic [7:0] payload_count_reg, payload_count_next;
    logic [7:0] store_reg [STORE_BYTES];

    logic       res_hit;
    logic       step;
    logic       store_we;
    logic [7:0] count_inc;
    logic [LEN_SUM_W-1:0] len_sum;

    // A good check byte produces a result; stall only then if the output is held
    assign res_hit  = (phase_reg == PH_CHECK) && (in_byte_reg == running_xor_reg);
    assign step     = in_valid_reg && (out_can_load || !res_hit);
    assign res_load = step && res_hit;
    assign rx.ready = !in_valid_reg || step;

    assign count_inc = payload_count_reg + 8'd1;
    assign len_sum   = {1'b0, in_byte_reg} + OverheadLen;
    assign store_we  = step && (phase_reg == PH_PAYLOAD) && (payload_count_reg < StoreBytes8);

    // Hold the accepted byte until the frame logic consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // Advance the frame state by one byte
    always_comb
    begin
        phase_next         = phase_reg;
        frame_length_next  = frame_length_reg;
        frame_command_next = frame_command_reg;
        running_xor_next   = running_xor_reg;
        payload_count_next = payload_count_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_HUNT2:
                begin
                    if (in_byte_reg == cfg.header_second)
                    begin
                        running_xor_next = cfg.header_first ^ in_byte_reg;
                        phase_next       = PH_LEN;
                    end
                    else if (in_byte_reg != cfg.header_first)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_LEN:
                begin
                    // Drop frames longer than the buffer allows
                    if (len_sum > LenLimit)
                    begin
                        phase_next = PH_HUNT1;
                    end
                    else
                    begin
                        frame_length_next = in_byte_reg;
                        running_xor_next  = running_xor_reg ^ in_byte_reg;
                        phase_next        = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    frame_command_next = in_byte_reg;
                    running_xor_next   = running_xor_reg ^ in_byte_reg;
                    payload_count_next = 8'd0;
                    phase_next         = (frame_length_reg == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    running_xor_next   = running_xor_reg ^ in_byte_reg;
                    payload_count_next = count_inc;
                    if (count_inc >= frame_length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT1;
                end
                default:
                begin
                    phase_next = (in_byte_reg == cfg.header_first) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT1;
            frame_length_reg  <= 8'd0;
            frame_command_reg <= 8'd0;
            running_xor_reg   <= 8'd0;
            payload_count_reg <= 8'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            frame_length_reg  <= frame_length_next;
            frame_command_reg <= frame_command_next;
            running_xor_reg   <= running_xor_next;
            payload_count_reg <= payload_count_next;
        end
    end

    // Keep the first payload bytes for decoding
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[payload_count_reg[STORE_IDX_W-1:0]] <= in_byte_reg;
        end
    end

    // Decode the finished frame; first matching command code wins
    always_comb
    begin
        res              = '0;
        res.action       = ACT_NONE;
        res.ack_code     = ACK_OK;
        res.command_echo = frame_command_reg;
        priority if (frame_command_reg == cfg.code_stop)
        begin
            if (frame_length_reg == LEN_STOP)
            begin
                res.action = ACT_STOP;
            end
            else
            begin
                res.ack_code = ACK_BAD_LEN;
            end
        end
        else if (frame_command_reg == cfg.code_set_velocity)
        begin
            if (frame_length_reg == LEN_SET_VEL)
            begin
                res.action      = ACT_SET_VEL;
                res.vel_forward = {store_reg[1], store_reg[0]};
                res.vel_side    = {store_reg[3], store_reg[2]};
                res.turn_rate   = {store_reg[5], store_reg[4]};
            end
            else
            begin
                res.ack_code = ACK_BAD_LEN;
            end
        end
        else if (frame_command_reg == cfg.code_tune_gains)
        begin
            if (frame_length_reg == LEN_TUNE)
            begin
                res.action      = ACT_TUNE;
                res.gain_p_bits = {store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
                res.gain_i_bits = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};
                res.gain_d_bits = {store_reg[11], store_reg[10], store_reg[9], store_reg[8]};
            end
            else
            begin
                res.ack_code = ACK_BAD_LEN;
            end
        end
        else if (frame_command_reg == cfg.code_status_request)
        begin
            res.action = ACT_STATUS;
        end
        else
        begin
            res.ack_code = ACK_UNKNOWN;
        end
    end

    // A result only leaves on a check byte
    a_load_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (phase_reg == PH_CHECK))
        else $error("result produced outside the check byte");

    // The payload count stays below the frame length while payload bytes arrive
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (payload_count_reg < frame_length_reg))
        else $error("payload count ran past the frame length");

    // A rejected command always carries an error code
    a_none_has_ack: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !((res.action == ACT_NONE) && (res.ack_code == ACK_OK)))
        else $error("rejected command without ack code");

    // A stored frame length always fits the receive buffer
    a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, frame_length_reg} + OverheadLen) <= LenLimit)
        else $error("frame length exceeds buffer limit");

endmodule : cfr_parser
`default_nettype wire

>>> rtl/core/cfr_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_out_reg
// Result register driving the decoded command channel.
// ----------------------------------------------------------------------------
module cfr_out_reg
    import cfr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  result_t    res_in,
    output logic       can_load,
    cfr_result_if.source result
);

    logic    valid_reg;
    result_t data_reg;

    // Slot frees when empty or when the held request is taken this cycle
    assign can_load = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign result.valid        = valid_reg;
    assign result.action       = data_reg.action;
    assign result.ack_code     = data_reg.ack_code;
    assign result.command_echo = data_reg.command_echo;
    assign result.vel_forward  = data_reg.vel_forward;
    assign result.vel_side     = data_reg.vel_side;
    assign result.turn_rate    = data_reg.turn_rate;
    assign result.gain_p_bits  = data_reg.gain_p_bits;
    assign result.gain_i_bits  = data_reg.gain_i_bits;
    assign result.gain_d_bits  = data_reg.gain_d_bits;

    // Never overwrite a request that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result.ready) |-> !load)
        else $error("held request overwritten");

endmodule : cfr_out_reg
`default_nettype wire

>>> bench/command_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_checker
// Watches the byte, register and decoded-command channels of the frame
// receiver. Every accepted byte runs through a local frame parser; each frame
// that passes its XOR check queues the decoded command it must produce. Each
// decoded command taken from the block is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
module command_frame_checker
    import cfr_pkg::*;
#(
    parameter int BUFFER_BYTES = RX_BUFFER_BYTES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    cfr_byte_if   rx,
    cfr_cfg_if    cfg,
    cfr_result_if result,
    output int    errors,
    output int    due_count
);

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        GET_LENGTH,
        GET_COMMAND,
        GET_PAYLOAD,
        GET_CHECK
    } parse_phase_t;

    cfg_t         regs;
    parse_phase_t phase;
    logic [7:0]   frame_len;
    logic [7:0]   frame_cmd;
    logic [7:0]   run_xor;
    logic [7:0]   pay_count;
    logic [7:0]   pay_mem [STORE_BYTES];
    result_t      commands_due [$];

    initial
    begin
        errors    = 0;
        due_count = 0;
    end

    // Print one line per mismatch and count it
    task automatic report_error(input string msg);
        errors++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    // Decode the frame just closed by a good check byte
    function automatic result_t decode_frame();
        result_t r;
        r              = '0;
        r.action       = ACT_NONE;
        r.ack_code     = ACK_OK;
        r.command_echo = frame_cmd;
        if (frame_cmd == regs.code_stop)
        begin
            if (frame_len == LEN_STOP)
                r.action = ACT_STOP;
            else
                r.ack_code = ACK_BAD_LEN;
        end
        else if (frame_cmd == regs.code_set_velocity)
        begin
            if (frame_len == LEN_SET_VEL)
            begin
                r.action      = ACT_SET_VEL;
                r.vel_forward = {pay_mem[1], pay_mem[0]};
                r.vel_side    = {pay_mem[3], pay_mem[2]};
                r.turn_rate   = {pay_mem[5], pay_mem[4]};
            end
            else
                r.ack_code = ACK_BAD_LEN;
        end
        else if (frame_cmd == regs.code_tune_gains)
        begin
            if (frame_len == LEN_TUNE)
            begin
                r.action      = ACT_TUNE;
                r.gain_p_bits = {pay_mem[3], pay_mem[2], pay_mem[1], pay_mem[0]};
                r.gain_i_bits = {pay_mem[7], pay_mem[6], pay_mem[5], pay_mem[4]};
                r.gain_d_bits = {pay_mem[11], pay_mem[10], pay_mem[9], pay_mem[8]};
            end
            else
                r.ack_code = ACK_BAD_LEN;
        end
        else if (frame_cmd == regs.code_status_request)
            r.action = ACT_STATUS;
        else
            r.ack_code = ACK_UNKNOWN;
        return r;
    endfunction

    // Advance the frame parser by one received byte
    task automatic parse_byte(input logic [7:0] b);
        case (phase)
            HUNT_SECOND:
            begin
                if (b == regs.header_second)
                begin
                    run_xor = regs.header_first ^ b;
                    phase   = GET_LENGTH;
                end
                else if (b != regs.header_first)
                    phase = HUNT_FIRST;
            end
            GET_LENGTH:
            begin
                // drop frames that would not fit the receive buffer
                if (int'(b) + FRAME_OVERHEAD > BUFFER_BYTES)
                    phase = HUNT_FIRST;
                else
                begin
                    frame_len = b;
                    run_xor   = run_xor ^ b;
                    phase     = GET_COMMAND;
                end
            end
            GET_COMMAND:
            begin
                frame_cmd = b;
                run_xor   = run_xor ^ b;
                pay_count = 8'd0;
                phase     = (frame_len == 8'd0) ? GET_CHECK : GET_PAYLOAD;
            end
            GET_PAYLOAD:
            begin
                // keep only the leading bytes; the rest just feed the XOR
                if (pay_count < STORE_BYTES)
                    pay_mem[pay_count[STORE_IDX_W-1:0]] = b;
                run_xor   = run_xor ^ b;
                pay_count = pay_count + 8'd1;
                if (pay_count >= frame_len)
                    phase = GET_CHECK;
            end
            GET_CHECK:
            begin
                if (b == run_xor)
                    commands_due.push_back(decode_frame());
                phase = HUNT_FIRST;
            end
            default:
                phase = (b == regs.header_first) ? HUNT_SECOND : HUNT_FIRST;
        endcase
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        case (idx)
            CFG_HEADER_FIRST:        regs.header_first        = val;
            CFG_HEADER_SECOND:       regs.header_second       = val;
            CFG_CODE_STOP:           regs.code_stop           = val;
            CFG_CODE_SET_VELOCITY:   regs.code_set_velocity   = val;
            CFG_CODE_TUNE_GAINS:     regs.code_tune_gains     = val;
            CFG_CODE_STATUS_REQUEST: regs.code_status_request = val;
            default: ;
        endcase
    endtask

    // Compare one decoded command against the oldest queued one
    task automatic compare_command();
        result_t want;
        if (commands_due.size() == 0)
        begin
            report_error($sformatf("unexpected command: action %0d, command %0h",
                                   result.action, result.command_echo));
            return;
        end
        want = commands_due.pop_front();
        check_field("action",       result.action,       want.action);
        check_field("ack_code",     result.ack_code,     want.ack_code);
        check_field("command_echo", result.command_echo, want.command_echo);
        check_field("vel_forward",  result.vel_forward,  want.vel_forward);
        check_field("vel_side",     result.vel_side,     want.vel_side);
        check_field("turn_rate",    result.turn_rate,    want.turn_rate);
        check_field("gain_p_bits",  result.gain_p_bits,  want.gain_p_bits);
        check_field("gain_i_bits",  result.gain_i_bits,  want.gain_i_bits);
        check_field("gain_d_bits",  result.gain_d_bits,  want.gain_d_bits);
    endtask

    // Sample every channel at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.header_first        = HEADER_FIRST_RST;
            regs.header_second       = HEADER_SECOND_RST;
            regs.code_stop           = CODE_STOP_RST;
            regs.code_set_velocity   = CODE_SET_VELOCITY_RST;
            regs.code_tune_gains     = CODE_TUNE_GAINS_RST;
            regs.code_status_request = CODE_STATUS_REQUEST_RST;
            phase     = HUNT_FIRST;
            frame_len = 8'd0;
            frame_cmd = 8'd0;
            run_xor   = 8'd0;
            pay_count = 8'd0;
            commands_due.delete();
            due_count = 0;
        end
        else
        begin
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
                write_register(cfg.index, cfg.data);
            if (result.valid === 1'b1 && result.ready === 1'b1)
                compare_command();
            if (rx.valid === 1'b1 && rx.ready === 1'b1)
                parse_byte(rx.rx_byte);
            due_count = commands_due.size();
        end
    end

endmodule : command_frame_checker

>>> bench/command_frame_receiver_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_receiver_top_tb
// Drives the frame receiver with a short directed byte sequence and then with
// mostly well-formed random frames (good, bad-length, unknown, overlong,
// corrupted and truncated) across several register settings, with random
// idle bursts on both handshake sides. The checker beside the block does the
// prediction and comparison; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module command_frame_receiver_top_tb;
    import cfr_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int N_PHASES      = 8;
    localparam int PHASE_BYTES   = 216;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 20;
    localparam int MAX_FIT_LEN   = RX_BUFFER_BYTES_DEF - FRAME_OVERHEAD;

    logic clk = 1'b0;
    logic rst_n;

    cfr_byte_if   rx_if ();
    cfr_cfg_if    cfg_if ();
    cfr_result_if result_if ();

    int         mismatches;
    int         due_count;
    int         idle_pct;
    int         rx_sent;
    logic [7:0] setting [6];
    logic [7:0] body_bytes [$];

    command_frame_receiver_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .cfg    (cfg_if),
        .result (result_if)
    );

    command_frame_checker frame_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .cfg       (cfg_if),
        .result    (result_if),
        .errors    (mismatches),
        .due_count (due_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop in case the handshake hangs
    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Stall the decoded-command channel in random bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_pct != 0 && $urandom_range(0, 299) < idle_pct)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            result_if.ready <= 1'b1;
        end
    end

    // Send one byte; returns at the falling edge after it is taken
    task automatic put_byte(input logic [7:0] b);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (rx_if.ready !== 1'b1);
        rx_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Hold input until every queued command has come out and the block is idle
    task automatic drain();
        rx_if.valid <= 1'b0;
        while (due_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Send a frame built from body_bytes; optionally corrupt the check byte
    // or cut the frame off right after the command byte
    task automatic send_framed(input logic [7:0] len, input logic [7:0] cmd,
                               input bit corrupt, input bit cut);
        logic [7:0] sum;
        put_byte(setting[CFG_HEADER_FIRST]);
        put_byte(setting[CFG_HEADER_SECOND]);
        sum = setting[CFG_HEADER_FIRST] ^ setting[CFG_HEADER_SECOND];
        put_byte(len);
        sum = sum ^ len;
        if (int'(len) + FRAME_OVERHEAD > RX_BUFFER_BYTES_DEF)
            return;
        put_byte(cmd);
        sum = sum ^ cmd;
        if (cut)
            return;
        foreach (body_bytes[i])
        begin
            put_byte(body_bytes[i]);
            sum = sum ^ body_bytes[i];
        end
        put_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
    endtask

    // Payload byte with a bias toward the int16 / word extremes
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_frame();
        int         pick;
        int         n;
        logic [7:0] cmd;
        logic [7:0] len;
        pick = $urandom_range(0, 99);
        // plain line noise, leaning on the first header byte
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 6))
                put_byte(($urandom_range(0, 3) == 0) ? setting[CFG_HEADER_FIRST]
                                                     : 8'($urandom_range(0, 255)));
            return;
        end
        // false starts ahead of the real frame
        if (pick < 20)
        begin
            put_byte(setting[CFG_HEADER_FIRST]);
            if (pick < 14)
                put_byte(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 9))
            0, 1:
            begin
                cmd = setting[CFG_CODE_STOP];
                len = LEN_STOP;
            end
            2, 3, 4:
            begin
                cmd = setting[CFG_CODE_SET_VELOCITY];
                len = LEN_SET_VEL;
            end
            5, 6:
            begin
                cmd = setting[CFG_CODE_TUNE_GAINS];
                len = LEN_TUNE;
            end
            7, 8:
            begin
                cmd = setting[CFG_CODE_STATUS_REQUEST];
                len = 8'($urandom_range(0, 20));
            end
            default:
            begin
                cmd = 8'($urandom_range(0, 255));
                len = 8'($urandom_range(0, 14));
            end
        endcase
        n = $urandom_range(0, 99);
        if (n < 12)
            len = 8'($urandom_range(0, MAX_FIT_LEN));
        else if (n < 16)
            len = 8'($urandom_range(MAX_FIT_LEN + 1, 255));
        body_bytes.delete();
        for (int i = 0; i < int'(len); i++)
            body_bytes.push_back(payload_byte());
        send_framed(len, cmd, $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 4);
    endtask

    // Pick and write a register setting for one phase of the run
    task automatic load_setting(input int which);
        logic [7:0] x;
        logic [7:0] y;
        x = 8'($urandom_range(0, 255));
        y = 8'($urandom_range(0, 255));
        case (which)
            1: setting = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F};
            // equal headers; stop shadows set velocity, tune shadows status
            2: setting = '{x, x, y, y, ~y, ~y};
            3: setting = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'h80};
            N_PHASES - 1:
                setting = '{HEADER_FIRST_RST, HEADER_SECOND_RST, CODE_STOP_RST,
                            CODE_SET_VELOCITY_RST, CODE_TUNE_GAINS_RST,
                            CODE_STATUS_REQUEST_RST};
            default:
                foreach (setting[i])
                    setting[i] = 8'($urandom_range(0, 255));
        endcase
        for (int i = 0; i < 6; i++)
            write_reg(CFG_IDX_W'(i), setting[i]);
        // an index past the last register must be ignored
        if (which % 2 == 0)
            write_reg(CFG_CODE_STATUS_REQUEST + CFG_IDX_W'($urandom_range(1, 2)),
                      8'($urandom_range(0, 255)));
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n            = 1'b0;
        rx_if.valid      = 1'b0;
        rx_if.rx_byte    = 8'h00;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_HEADER_FIRST;
        cfg_if.data      = 8'h00;
        result_if.ready  = 1'b0;
        idle_pct         = 0;
        rx_sent          = 0;
        setting = '{HEADER_FIRST_RST, HEADER_SECOND_RST, CODE_STOP_RST,
                    CODE_SET_VELOCITY_RST, CODE_TUNE_GAINS_RST, CODE_STATUS_REQUEST_RST};
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // stop frame behind a repeated first header byte
        body_bytes.delete();
        put_byte(setting[CFG_HEADER_FIRST]);
        send_framed(LEN_STOP, setting[CFG_CODE_STOP], 1'b0, 1'b0);
        // set velocity with most negative, most positive and minus one
        body_bytes = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF};
        send_framed(LEN_SET_VEL, setting[CFG_CODE_SET_VELOCITY], 1'b0, 1'b0);
        // overlong length, dropped at the length byte
        body_bytes.delete();
        send_framed(8'hFF, setting[CFG_CODE_STATUS_REQUEST], 1'b0, 1'b0);
        // status request with a bad check byte
        send_framed(LEN_STOP, setting[CFG_CODE_STATUS_REQUEST], 1'b1, 1'b0);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                load_setting(p);
            end
            case (p)
                0:       idle_pct = 10;
                1:       idle_pct = 4;
                3:       idle_pct = 25;
                5:       idle_pct = 15;
                6:       idle_pct = 8;
                default: idle_pct = 0;
            endcase
            while (rx_sent < (p + 1) * PHASE_BYTES)
                random_frame();
        end

        // wait out every queued command, then let the block settle
        rx_if.valid <= 1'b0;
        while (due_count != 0) @(negedge clk);
        repeat (END_CYCLES) @(negedge clk);
        if (mismatches == 0 && due_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule : command_frame_receiver_top_tb

>>> sim.f
rtl/core/cfr_pkg.sv
rtl/core/cfr_byte_if.sv
rtl/core/cfr_cfg_if.sv
rtl/core/cfr_result_if.sv
rtl/core/cfr_cfg_regs.sv
rtl/core/cfr_parser.sv
rtl/core/cfr_out_reg.sv
rtl/core/command_frame_receiver_top.sv
bench/command_frame_checker.sv
bench/command_frame_receiver_top_tb.sv
